>>> sv/scc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, operand select codes and control structs of the segment collision check.
package scc_pkg;

  localparam int CRD_W = 32;   // Q16.16 coordinate
  localparam int DIF_W = 33;   // coordinate difference
  localparam int MUL_W = 34;   // multiplier operand
  localparam int PRD_W = 68;   // multiplier product and cross products
  localparam int NUM_W = 67;   // magnitude of the crossing numerator
  localparam int CHK_W = 33;   // numerator chunk for the wide product
  localparam int WPR_W = 100;  // wide product numerator times direction
  localparam int QUO_W = 33;   // quotient of the wide division
  localparam int SQ_W  = 64;   // squared distance
  localparam int DST_W = 32;   // distance
  localparam int CAP_W = 31;   // distance cap and reported minimum

  localparam logic [CAP_W-1:0] CAP_RESET = 31'd655360;

  typedef enum logic [3:0] {
    MS_BX_CY,
    MS_BY_CX,
    MS_BX_DY,
    MS_BY_DX,
    MS_CX_DY,
    MS_CY_DX,
    MS_MX_MX,
    MS_MY_MY,
    MS_CHUNK0,
    MS_CHUNK1,
    MS_CHUNK2
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     prep;
    logic     div_start;
    logic     coord;
    logic     store;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_idle;
  } status_t;

endpackage

>>> sv/scc_div.sv
`timescale 1ns / 1ps
// Restoring divider that yields one quotient bit per cycle for the crossing point.
module scc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [scc_pkg::WPR_W-1:0]  dividend_i,
  input  logic [scc_pkg::PRD_W-1:0]  divisor_i,
  output logic [scc_pkg::QUO_W-1:0]  quo_o,
  output logic                       rem_nz_o,
  output logic                       done_o
);

  logic [scc_pkg::PRD_W-1:0] rem_q, rem_d;
  logic [scc_pkg::QUO_W-1:0] low_q, low_d;
  logic [scc_pkg::QUO_W-1:0] quo_q, quo_d;
  logic [5:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [scc_pkg::PRD_W:0]   rem2;
  logic [scc_pkg::PRD_W:0]   diff;
  logic                      qbit;

  always_comb begin
    rem2  = {rem_q, low_q[scc_pkg::QUO_W-1]};
    diff  = rem2 - {1'b0, divisor_i};
    qbit  = (rem2 >= {1'b0, divisor_i});
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, dividend_i[scc_pkg::WPR_W-1:scc_pkg::QUO_W]};
      low_d  = dividend_i[scc_pkg::QUO_W-1:0];
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = qbit ? diff[scc_pkg::PRD_W-1:0] : rem2[scc_pkg::PRD_W-1:0];
      low_d = {low_q[scc_pkg::QUO_W-2:0], 1'b0};
      quo_d = {quo_q[scc_pkg::QUO_W-2:0], qbit};
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(scc_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign quo_o    = quo_q;
  assign rem_nz_o = |rem_q;
  assign done_o   = done_q;

endmodule

>>> sv/scc_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one result bit per cycle.
module scc_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [scc_pkg::SQ_W-1:0]  rad_i,
  output logic [scc_pkg::DST_W-1:0] root_o,
  output logic                      idle_o
);

  logic [scc_pkg::SQ_W-1:0]    rad_q, rad_d;
  logic [scc_pkg::DST_W+1:0]   rem_q, rem_d;
  logic [scc_pkg::DST_W-1:0]   root_q, root_d;
  logic [5:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic [scc_pkg::DST_W+1:0]   rem2;
  logic [scc_pkg::DST_W+1:0]   trial;

  always_comb begin
    rem2   = {rem_q[scc_pkg::DST_W-1:0], rad_q[scc_pkg::SQ_W-1:scc_pkg::SQ_W-2]};
    trial  = {root_q, 2'b01};
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rad_d  = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d = {rad_q[scc_pkg::SQ_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_d  = rem2 - trial;
        root_d = {root_q[scc_pkg::DST_W-2:0], 1'b1};
      end else begin
        rem_d  = rem2;
        root_d = {root_q[scc_pkg::DST_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(scc_pkg::DST_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign root_o = root_q;
  assign idle_o = !busy_q;

endmodule

>>> sv/scc_datapath.sv
`timescale 1ns / 1ps
// Datapath: operand registers, shared multiplier, crossing test, running state and result word.
module scc_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [scc_pkg::CAP_W-1:0]        cfg_data_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_a_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_a_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_b_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_b_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_c_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_c_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_d_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_d_y_i,
  input  logic                             first_pair_i,
  input  logic                             last_pair_i,
  input  scc_pkg::cmd_t                    cmd_i,
  output scc_pkg::status_t                 status_o,
  output logic                             hit_o,
  output logic signed [scc_pkg::CRD_W-1:0] cross_x_o,
  output logic signed [scc_pkg::CRD_W-1:0] cross_y_o,
  output logic [scc_pkg::CAP_W-1:0]        min_distance_o,
  output logic                             collision_free_o,
  output logic                             last_out_o
);

  logic [scc_pkg::CAP_W-1:0]        cap_q;
  logic [scc_pkg::DST_W-1:0]        run_min_q;
  logic                             free_q;

  logic signed [scc_pkg::CRD_W-1:0] ax_q, ay_q;
  logic signed [scc_pkg::DIF_W-1:0] bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic [scc_pkg::DIF_W-1:0]        mx_q, my_q;
  logic                             degen_q, far_q, last_q;

  logic signed [scc_pkg::MUL_W-1:0] op_a, op_b;
  logic signed [scc_pkg::PRD_W-1:0] pr_q;
  logic                             acc_en_q;
  scc_pkg::mul_sel_e                acc_sel_q;

  logic signed [scc_pkg::PRD_W-1:0] sc_q, sd_q, num_q, den_q;
  logic [scc_pkg::SQ_W-1:0]         sq_q;
  logic [scc_pkg::NUM_W-1:0]        num_mag_q;
  logic                             hit_ok_q;
  logic [scc_pkg::WPR_W-1:0]        prod_q;
  logic [scc_pkg::CRD_W-1:0]        px_q, py_q;

  logic                             hit_q, free_out_q, last_out_q;
  logic [scc_pkg::CRD_W-1:0]        cross_x_q, cross_y_q;
  logic [scc_pkg::CAP_W-1:0]        min_out_q;

  logic signed [scc_pkg::DIF_W-1:0] mdx, mdy;
  logic                             same_ab, same_cd, same_ac, same_bc, same_ad, same_bd;
  logic signed [scc_pkg::PRD_W-1:0] den_raw, den_f, num_f;
  logic                             hit_ok_d;
  logic signed [scc_pkg::DIF_W-1:0] bsel;
  logic [scc_pkg::DIF_W-1:0]        bmag;
  logic [scc_pkg::QUO_W-1:0]        quo;
  logic                             rem_nz, div_done;
  logic [scc_pkg::QUO_W:0]          qs;
  logic [scc_pkg::CRD_W-1:0]        pt;
  logic [scc_pkg::DST_W-1:0]        root_dist;
  logic                             sqrt_idle;
  logic [scc_pkg::DST_W-1:0]        min_new;
  logic                             free_new;

  function automatic logic signed [scc_pkg::DIF_W-1:0] DIF_SEXT(
    input logic signed [scc_pkg::CRD_W-1:0] v
  );
    return {v[scc_pkg::CRD_W-1], v};
  endfunction

  always_comb begin
    mdx = DIF_SEXT(seg_a_x_i) - DIF_SEXT(obs_c_x_i);
    mdy = DIF_SEXT(seg_a_y_i) - DIF_SEXT(obs_c_y_i);
    same_ab = (seg_a_x_i == seg_b_x_i) && (seg_a_y_i == seg_b_y_i);
    same_cd = (obs_c_x_i == obs_d_x_i) && (obs_c_y_i == obs_d_y_i);
    same_ac = (seg_a_x_i == obs_c_x_i) && (seg_a_y_i == obs_c_y_i);
    same_bc = (seg_b_x_i == obs_c_x_i) && (seg_b_y_i == obs_c_y_i);
    same_ad = (seg_a_x_i == obs_d_x_i) && (seg_a_y_i == obs_d_y_i);
    same_bd = (seg_b_x_i == obs_d_x_i) && (seg_b_y_i == obs_d_y_i);
  end

  // Input word and differences relative to A.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q    <= seg_a_x_i;
      ay_q    <= seg_a_y_i;
      bx_q    <= DIF_SEXT(seg_b_x_i) - DIF_SEXT(seg_a_x_i);
      by_q    <= DIF_SEXT(seg_b_y_i) - DIF_SEXT(seg_a_y_i);
      cx_q    <= DIF_SEXT(obs_c_x_i) - DIF_SEXT(seg_a_x_i);
      cy_q    <= DIF_SEXT(obs_c_y_i) - DIF_SEXT(seg_a_y_i);
      dx_q    <= DIF_SEXT(obs_d_x_i) - DIF_SEXT(seg_a_x_i);
      dy_q    <= DIF_SEXT(obs_d_y_i) - DIF_SEXT(seg_a_y_i);
      mx_q    <= mdx[scc_pkg::DIF_W-1] ? -mdx : mdx;
      my_q    <= mdy[scc_pkg::DIF_W-1] ? -mdy : mdy;
      degen_q <= same_ab | same_cd | same_ac | same_bc | same_ad | same_bd;
      last_q  <= last_pair_i;
    end
  end

  assign far_q = mx_q[scc_pkg::DIF_W-1] | mx_q[scc_pkg::DIF_W-2] |
                 my_q[scc_pkg::DIF_W-1] | my_q[scc_pkg::DIF_W-2];

  assign bsel = cmd_i.coord ? by_q : bx_q;
  assign bmag = bsel[scc_pkg::DIF_W-1] ? -bsel : bsel;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      scc_pkg::MS_BX_CY: begin op_a = {bx_q[32], bx_q}; op_b = {cy_q[32], cy_q}; end
      scc_pkg::MS_BY_CX: begin op_a = {by_q[32], by_q}; op_b = {cx_q[32], cx_q}; end
      scc_pkg::MS_BX_DY: begin op_a = {bx_q[32], bx_q}; op_b = {dy_q[32], dy_q}; end
      scc_pkg::MS_BY_DX: begin op_a = {by_q[32], by_q}; op_b = {dx_q[32], dx_q}; end
      scc_pkg::MS_CX_DY: begin op_a = {cx_q[32], cx_q}; op_b = {dy_q[32], dy_q}; end
      scc_pkg::MS_CY_DX: begin op_a = {cy_q[32], cy_q}; op_b = {dx_q[32], dx_q}; end
      scc_pkg::MS_MX_MX: begin op_a = {1'b0, mx_q}; op_b = {1'b0, mx_q}; end
      scc_pkg::MS_MY_MY: begin op_a = {1'b0, my_q}; op_b = {1'b0, my_q}; end
      scc_pkg::MS_CHUNK0: begin
        op_a = {1'b0, num_mag_q[scc_pkg::CHK_W-1:0]};
        op_b = {1'b0, bmag};
      end
      scc_pkg::MS_CHUNK1: begin
        op_a = {1'b0, num_mag_q[2*scc_pkg::CHK_W-1:scc_pkg::CHK_W]};
        op_b = {1'b0, bmag};
      end
      scc_pkg::MS_CHUNK2: begin
        op_a = {33'b0, num_mag_q[scc_pkg::NUM_W-1]};
        op_b = {1'b0, bmag};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q      <= op_a * op_b;
    acc_sel_q <= cmd_i.mul_sel;
    if (acc_en_q) begin
      case (acc_sel_q)
        scc_pkg::MS_BX_CY:  sc_q   <= pr_q;
        scc_pkg::MS_BY_CX:  sc_q   <= sc_q - pr_q;
        scc_pkg::MS_BX_DY:  sd_q   <= pr_q;
        scc_pkg::MS_BY_DX:  sd_q   <= sd_q - pr_q;
        scc_pkg::MS_CX_DY:  num_q  <= pr_q;
        scc_pkg::MS_CY_DX:  num_q  <= num_q - pr_q;
        scc_pkg::MS_MX_MX:  sq_q   <= pr_q[scc_pkg::SQ_W-1:0];
        scc_pkg::MS_MY_MY:  sq_q   <= sq_q + pr_q[scc_pkg::SQ_W-1:0];
        scc_pkg::MS_CHUNK0: prod_q <= {32'b0, pr_q};
        scc_pkg::MS_CHUNK1: prod_q <= prod_q + {pr_q[66:0], 33'b0};
        scc_pkg::MS_CHUNK2: prod_q <= prod_q + {pr_q[33:0], 66'b0};
        default:            prod_q <= prod_q;
      endcase
    end
  end

  // Side test and orientation of the crossing fraction.
  always_comb begin
    den_raw  = sd_q - sc_q;
    den_f    = den_raw[scc_pkg::PRD_W-1] ? -den_raw : den_raw;
    num_f    = den_raw[scc_pkg::PRD_W-1] ? -num_q : num_q;
    hit_ok_d = !degen_q && (sc_q[scc_pkg::PRD_W-1] != sd_q[scc_pkg::PRD_W-1]) &&
               !num_f[scc_pkg::PRD_W-1] && ($unsigned(num_f) <= $unsigned(den_f));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      den_q     <= den_f;
      num_mag_q <= num_f[scc_pkg::NUM_W-1:0];
      hit_ok_q  <= hit_ok_d;
    end
  end

  scc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (den_q),
    .quo_o      (quo),
    .rem_nz_o   (rem_nz),
    .done_o     (div_done)
  );

  scc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.prep),
    .rad_i   (sq_q),
    .root_o  (root_dist),
    .idle_o  (sqrt_idle)
  );

  // Floor of the signed quotient, then offset from A.
  always_comb begin
    qs = bsel[scc_pkg::DIF_W-1] ? (-{1'b0, quo} - {{scc_pkg::QUO_W{1'b0}}, rem_nz})
                                : {1'b0, quo};
    pt = (cmd_i.coord ? ay_q : ax_q) + qs[scc_pkg::CRD_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      if (cmd_i.coord) begin
        py_q <= pt;
      end else begin
        px_q <= pt;
      end
    end
  end

  assign min_new  = (!far_q && (root_dist < run_min_q)) ? root_dist : run_min_q;
  assign free_new = free_q & !hit_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= scc_pkg::CAP_RESET;
      run_min_q  <= {1'b0, scc_pkg::CAP_RESET};
      free_q     <= 1'b1;
      hit_q      <= 1'b0;
      cross_x_q  <= '0;
      cross_y_q  <= '0;
      min_out_q  <= '0;
      free_out_q <= 1'b1;
      last_out_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.load && first_pair_i) begin
        run_min_q <= {1'b0, cap_q};
        free_q    <= 1'b1;
      end else if (cmd_i.publish) begin
        run_min_q <= min_new;
        free_q    <= free_new;
      end
      if (cmd_i.publish) begin
        hit_q      <= hit_ok_q;
        cross_x_q  <= hit_ok_q ? px_q : '0;
        cross_y_q  <= hit_ok_q ? py_q : '0;
        min_out_q  <= min_new[scc_pkg::CAP_W-1:0];
        free_out_q <= free_new;
        last_out_q <= last_q;
      end
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.sqrt_idle = sqrt_idle;

  assign hit_o            = hit_q;
  assign cross_x_o        = cross_x_q;
  assign cross_y_o        = cross_y_q;
  assign min_distance_o   = min_out_q;
  assign collision_free_o = free_out_q;
  assign last_out_o       = last_out_q;

  a_hit_clears_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> !free_out_q)
    else $error("A hit word reports the trajectory as collision free.");

  a_miss_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_q |-> (cross_x_q == '0) && (cross_y_q == '0))
    else $error("A word without a hit carries a crossing point.");

  a_min_not_rising: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.publish && !$past(cmd_i.load && first_pair_i)) |=>
      (run_min_q <= $past(run_min_q)))
    else $error("The running minimum distance grew without a first pair.");

endmodule

>>> sv/scc_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences the multiplier, divider and square root and owns the handshakes.
module scc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  scc_pkg::status_t  status_i,
  output scc_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_PREP   = 3'd2;
  localparam logic [2:0] S_WMUL   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       coord_q, coord_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    coord_d     = coord_q;
    cmd_o       = '0;
    cmd_o.coord = coord_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt_q < 4'd8) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = scc_pkg::mul_sel_e'(cnt_q);
          cnt_d         = cnt_q + 4'd1;
        end else begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        coord_d    = 1'b0;
        state_d    = S_WMUL;
      end
      S_WMUL: begin
        case (cnt_q[1:0])
          2'd0: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = scc_pkg::MS_CHUNK0; end
          2'd1: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = scc_pkg::MS_CHUNK1; end
          2'd2: begin cmd_o.mul_en = 1'b1; cmd_o.mul_sel = scc_pkg::MS_CHUNK2; end
          default: cmd_o.mul_en = 1'b0;
        endcase
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd3) begin
          state_d = S_DSTART;
        end
      end
      S_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV;
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.store = 1'b1;
          cnt_d       = '0;
          if (coord_q) begin
            state_d = S_DONE;
          end else begin
            coord_d = 1'b1;
            state_d = S_WMUL;
          end
        end
      end
      S_DONE: begin
        if (status_i.sqrt_idle && (!out_valid_q || out_ready_i)) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      coord_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      coord_q     <= coord_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_publish_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("A result word overwrote one not yet taken.");

  a_store_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.store |-> (state_q == S_DIV) && status_i.div_done)
    else $error("A crossing coordinate was stored without a finished division.");

endmodule

>>> sv/segment_collision_check.sv
`timescale 1ns / 1ps
// Top level of the segment collision check.
// Usage: each input word carries one vehicle segment A-B and one obstacle segment C-D in
// signed Q16.16, plus first and last marks. It is taken with in_valid_i and in_ready_o and
// yields exactly one result word on out_valid_o and out_ready_i: the hit flag, the crossing
// point floored to the Q16.16 grid, the running minimum A-to-C distance and the
// collision-free flag. One word is in work at a time. The two divisions for the crossing point
// follow the eight products of the shared 34 by 34 multiplier. The 32-step square root for
// the distance runs beside the divisions. A finished result sits in the output register, so
// the next input word is accepted while it waits; if the receiver stalls longer, the block
// holds the next result until the output register is free. The distance cap is written
// through cfg_valid_i and cfg_data_i and is loaded into the running minimum by the next word
// marked first; the user must write it only while the block is idle, which the block itself
// does not enforce. Reset sets the cap to 10.0, the running minimum to the cap and the
// collision-free flag to one, and empties the output register.
module segment_collision_check (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [scc_pkg::CAP_W-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_a_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_a_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_b_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] seg_b_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_c_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_c_y_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_d_x_i,
  input  logic signed [scc_pkg::CRD_W-1:0] obs_d_y_i,
  input  logic                             first_pair_i,
  input  logic                             last_pair_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic signed [scc_pkg::CRD_W-1:0] cross_x_o,
  output logic signed [scc_pkg::CRD_W-1:0] cross_y_o,
  output logic [scc_pkg::CAP_W-1:0]        min_distance_o,
  output logic                             collision_free_o,
  output logic                             last_out_o
);

  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  scc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  scc_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .seg_a_x_i        (seg_a_x_i),
    .seg_a_y_i        (seg_a_y_i),
    .seg_b_x_i        (seg_b_x_i),
    .seg_b_y_i        (seg_b_y_i),
    .obs_c_x_i        (obs_c_x_i),
    .obs_c_y_i        (obs_c_y_i),
    .obs_d_x_i        (obs_d_x_i),
    .obs_d_y_i        (obs_d_y_i),
    .first_pair_i     (first_pair_i),
    .last_pair_i      (last_pair_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .hit_o            (hit_o),
    .cross_x_o        (cross_x_o),
    .cross_y_o        (cross_y_o),
    .min_distance_o   (min_distance_o),
    .collision_free_o (collision_free_o),
    .last_out_o       (last_out_o)
  );

endmodule

>>> tb/sv/tb_segment_collision_check.sv
`timescale 1ns / 1ps
// Self-checking testbench of the segment collision check with a built-in crossing predictor.
module tb_segment_collision_check;

  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic first, last;
  } pair_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] px, py;
    logic [30:0] min_dist;
    logic free;
    logic last;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [scc_pkg::CAP_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] seg_a_x_i = '0, seg_a_y_i = '0, seg_b_x_i = '0, seg_b_y_i = '0;
  logic signed [31:0] obs_c_x_i = '0, obs_c_y_i = '0, obs_d_x_i = '0, obs_d_y_i = '0;
  logic first_pair_i = 1'b0, last_pair_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic hit_o, collision_free_o, last_out_o;
  logic signed [31:0] cross_x_o, cross_y_o;
  logic [scc_pkg::CAP_W-1:0] min_distance_o;

  logic [30:0] cap_reg;
  logic [31:0] run_min;
  logic free_reg;
  verdict_t pending_mem [0:2047];
  int pend_wr;
  int pend_rd;
  int mismatches;
  bit quiet;

  segment_collision_check dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] isqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [127:0] floor_div(logic signed [127:0] n,
                                                    logic signed [127:0] d);
    logic signed [127:0] q;
    q = n / d;
    if ((n % d != 0) && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic verdict_t predict_crossing(pair_t p);
    verdict_t v;
    logic signed [63:0] ex, ey, bx, by, cx, cy, dx, dy;
    logic [63:0] mx, my;
    logic signed [127:0] sc, sd, num, den;
    logic [63:0] dd;
    v = '0;
    if (p.first) begin
      run_min = {1'b0, cap_reg};
      free_reg = 1'b1;
    end
    ex = 64'(p.ax) - 64'(p.cx);
    ey = 64'(p.ay) - 64'(p.cy);
    mx = ex < 0 ? -ex : ex;
    my = ey < 0 ? -ey : ey;
    if (mx < 64'h8000_0000 && my < 64'h8000_0000) begin
      dd = isqrt(mx * mx + my * my);
      if (dd < 64'(run_min)) run_min = dd[31:0];
    end
    if (!((p.ax == p.bx && p.ay == p.by) || (p.cx == p.dx && p.cy == p.dy)) &&
        !((p.ax == p.cx && p.ay == p.cy) || (p.bx == p.cx && p.by == p.cy) ||
          (p.ax == p.dx && p.ay == p.dy) || (p.bx == p.dx && p.by == p.dy))) begin
      bx = 64'(p.bx) - 64'(p.ax);  by = 64'(p.by) - 64'(p.ay);
      cx = 64'(p.cx) - 64'(p.ax);  cy = 64'(p.cy) - 64'(p.ay);
      dx = 64'(p.dx) - 64'(p.ax);  dy = 64'(p.dy) - 64'(p.ay);
      sc = 128'(bx) * 128'(cy) - 128'(by) * 128'(cx);
      sd = 128'(bx) * 128'(dy) - 128'(by) * 128'(dx);
      if ((sc < 0) != (sd < 0)) begin
        num = 128'(cx) * 128'(dy) - 128'(cy) * 128'(dx);
        den = sd - sc;
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        if (num >= 0 && num <= den) begin
          v.hit = 1'b1;
          v.px = 32'(128'(p.ax) + floor_div(num * 128'(bx), den));
          v.py = 32'(128'(p.ay) + floor_div(num * 128'(by), den));
          free_reg = 1'b0;
        end
      end
    end
    v.min_dist = run_min[30:0];
    v.free = free_reg;
    v.last = p.last;
    return v;
  endfunction

  task automatic idle_burst();
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) @(negedge clk_i);
  endtask

  task automatic send_pair(pair_t p);
    idle_burst();
    {seg_a_x_i, seg_a_y_i, seg_b_x_i, seg_b_y_i} = {p.ax, p.ay, p.bx, p.by};
    {obs_c_x_i, obs_c_y_i, obs_d_x_i, obs_d_y_i} = {p.cx, p.cy, p.dx, p.dy};
    first_pair_i = p.first;
    last_pair_i = p.last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_mem[pend_wr] = predict_crossing(p);
    pend_wr++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (pend_rd != pend_wr) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_cap(logic [30:0] value);
    drain();
    cfg_data_i = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cap_reg = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [31:0] any_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      2: return $signed($urandom_range(0, 64)) - 32;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  // Builds a pair whose obstacle straddles the vehicle path most of the time.
  function automatic pair_t crossing_pair(int span);
    pair_t p;
    logic signed [31:0] mx, my;
    p.ax = $signed($urandom_range(0, 2 * span)) - span;
    p.ay = $signed($urandom_range(0, 2 * span)) - span;
    p.bx = $signed($urandom_range(0, 2 * span)) - span;
    p.by = $signed($urandom_range(0, 2 * span)) - span;
    mx = (p.ax >>> 1) + (p.bx >>> 1);
    my = (p.ay >>> 1) + (p.by >>> 1);
    p.cx = mx + $signed($urandom_range(0, span)) - span / 2;
    p.cy = my + $signed($urandom_range(0, span)) - span / 2;
    p.dx = 2 * mx - p.cx + $signed($urandom_range(0, 8)) - 4;
    p.dy = 2 * my - p.cy + $signed($urandom_range(0, 8)) - 4;
    p.first = ($urandom_range(0, 7) == 0);
    p.last = $urandom_range(0, 1);
    return p;
  endfunction

  task automatic test_corners();
    pair_t p;
    p = '{0, 0, 32'sh10000, 32'sh10000, 0, 32'sh10000, 32'sh10000, 0, 1'b1, 1'b0};
    send_pair(p);
    p = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 1'b0, 1'b1};
    send_pair(p);
    p = '{5, 5, 5, 5, 0, 1, 9, 1, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 3, 3, 3, 3, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 0, 0, 5, 5, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 10, 0, 5, -5, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 5, 0, 5, 5, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 5, 5, 5, 0, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 10, -5, 10, 5, 1'b0, 1'b0};
    send_pair(p);
    p = '{0, 0, 10, 0, 11, -5, 11, 5, 1'b0, 1'b1};
    send_pair(p);
    p = '{0, 0, 3, 7, 2, -1, -1, 5, 1'b1, 1'b0};
    send_pair(p);
    p = '{-3, 1, 4, -9, 8, 2, -8, -3, 1'b0, 1'b1};
    send_pair(p);
    p = '{32'sh7fff_ffff, 0, 0, 0, 32'sh8000_0000, 0, 0, 5, 1'b0, 1'b0};
    send_pair(p);
    p = '{32'sh7fff_ffff, 32'sh7fff_ffff, 0, 1, 32'sh7fff_0000, 32'sh7fff_0000, 3, 3,
          1'b0, 1'b1};
    send_pair(p);
  endtask

  task automatic test_random(int count, int span);
    pair_t p;
    repeat (count) begin
      if ($urandom_range(0, 9) < 7) begin
        p = crossing_pair(span);
      end else begin
        p = {any_coord(), any_coord(), any_coord(), any_coord(),
             any_coord(), any_coord(), any_coord(), any_coord(),
             1'($urandom()), 1'($urandom())};
      end
      send_pair(p);
    end
  endtask

  task automatic test_cap_settings();
    write_cap('0);
    test_random(80, 1 << 20);
    write_cap(31'h7fff_ffff);
    test_random(120, 32'h3fff_ffff);
    write_cap(31'($urandom()));
    test_random(80, 1 << 12);
    write_cap(scc_pkg::CAP_RESET);
  endtask

  initial begin
    mismatches = 0;
    quiet = 1'b0;
    cap_reg = scc_pkg::CAP_RESET;
    run_min = {1'b0, scc_pkg::CAP_RESET};
    free_reg = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    test_corners();
    test_cap_settings();
    test_random(900, 1 << 22);
    quiet = 1'b1;
    test_random(150, 1 << 18);
    drain();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t got, exp_v;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{hit_o, cross_x_o, cross_y_o, min_distance_o, collision_free_o, last_out_o};
      if (pend_rd == pend_wr) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %p", got);
      end else begin
        exp_v = pending_mem[pend_rd];
        pend_rd++;
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", exp_v, got);
        end
      end
    end
  end

endmodule
